@@ sv/grayscale_sobel_edge_filter_assert.svh @@
// Assertion macros for the edge filter RTL.
`ifndef GRAYSCALE_SOBEL_EDGE_FILTER_ASSERT_SVH
`define GRAYSCALE_SOBEL_EDGE_FILTER_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define GSEF_ASSERT_ALWAYS(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define GSEF_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GSEF_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/gsef_pkg.sv @@
`default_nettype none
package gsef_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  localparam int DIM_W     = 12;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(MAX_HEIGHT);
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);
  localparam logic [DIM_W-1:0] MIN_DIM      = DIM_W'(3);

  localparam logic [7:0] WEIGHT_RED   = 8'd77;
  localparam logic [7:0] WEIGHT_GREEN = 8'd150;
  localparam logic [7:0] WEIGHT_BLUE  = 8'd29;
  localparam int         GRAY_SHIFT   = 8;
  localparam logic [7:0] EDGE_MAX     = 8'd255;

  typedef struct packed {
    logic [7:0]       gray;
    logic [COL_W-1:0] col;
    logic             interior;
    logic             last;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Last valid position along one dimension, with the size held to 3..hi.
  function automatic logic [COL_W-1:0] dim_last(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] c;
    if (v < MIN_DIM) begin
      c = MIN_DIM;
    end else if (v > hi) begin
      c = hi;
    end else begin
      c = v;
    end
    return COL_W'(c - DIM_W'(1));
  endfunction

endpackage
`default_nettype wire

@@ sv/gsef_front.sv @@
`default_nettype none
module gsef_front import gsef_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [7:0]           blue,
  input  wire logic [7:0]           green,
  input  wire logic [7:0]           red,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0]     cfg_data,
  input  wire q_stat_t              q_stat,
  output logic                      q_push,
  output q_entry_t                  q_wdata
);

  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col_last;
  logic [ROW_W-1:0] row_last;
  logic             col_end;
  logic             row_end;
  logic             cfg_hit;
  logic [15:0]      luma_sum;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_stat.full;
  assign q_push    = in_valid && in_ready;

  assign col_last = dim_last(frame_width, DIM_W'(MAX_WIDTH));
  assign row_last = ROW_W'(dim_last(frame_height, DIM_W'(MAX_HEIGHT)));
  assign col_end  = col >= col_last;
  assign row_end  = row >= row_last;

  assign luma_sum = 16'(WEIGHT_RED) * 16'(red) + 16'(WEIGHT_GREEN) * 16'(green)
                  + 16'(WEIGHT_BLUE) * 16'(blue);

  always_comb begin
    q_wdata.gray     = luma_sum[GRAY_SHIFT +: 8];
    q_wdata.col      = col;
    q_wdata.interior = (row >= ROW_W'(2)) && (col >= COL_W'(2));
    q_wdata.last     = row_end && col_end;
  end

  always_comb begin
    unique case (cfg_index)
      REG_FRAME_WIDTH:  cfg_hit = cfg_valid;
      REG_FRAME_HEIGHT: cfg_hit = cfg_valid;
      default:          cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
      col          <= '0;
      row          <= '0;
    end else if (cfg_hit) begin
      // A write to either frame register restarts the frame position.
      if (cfg_index == REG_FRAME_WIDTH) begin
        frame_width <= cfg_data;
      end else begin
        frame_height <= cfg_data;
      end
      col <= '0;
      row <= '0;
    end else if (q_push) begin
      if (col_end) begin
        col <= '0;
        row <= row_end ? '0 : row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/gsef_queue.sv @@
`default_nettype none
module gsef_queue import gsef_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire q_entry_t wdata,
  input  wire logic     pop,
  output q_entry_t      rdata,
  output q_stat_t       stat
);

  q_entry_t    entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign stat.full  = count == 2'd2;
  assign stat.empty = count == 2'd0;
  assign rdata      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/gsef_back.sv @@
`default_nettype none
module gsef_back import gsef_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire q_entry_t q_rdata,
  input  wire q_stat_t  q_stat,
  output logic          q_pop,
  output logic          out_valid,
  input  wire logic     out_ready,
  output logic [7:0]    edge_res,
  output logic          interior,
  output logic          frame_end
);

  logic [7:0] line_above     [MAX_WIDTH];
  logic [7:0] line_two_above [MAX_WIDTH];

  q_entry_t    s1;
  logic        s1_valid;
  logic        s1_move;
  logic [7:0]  rd_above;
  logic [7:0]  rd_two_above;
  logic [7:0]  win [6];

  logic signed [11:0] gx;
  logic signed [11:0] gy;
  logic        [11:0] abs_gx;
  logic        [11:0] abs_gy;
  logic        [11:0] mag;
  logic        [7:0]  mag_sat;

  assign s1_move = s1_valid && (!out_valid || out_ready);
  assign q_pop   = !q_stat.empty && (!s1_valid || s1_move);

  // Line buffers: read when an entry leaves the queue, written when it
  // moves on. Neighboring items share a column only across a frame register
  // write; otherwise the two ports never touch the same entry in one cycle.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_above     <= line_above[q_rdata.col];
      rd_two_above <= line_two_above[q_rdata.col];
    end
    if (s1_move) begin
      line_two_above[s1.col] <= rd_above;
      line_above[s1.col]     <= s1.gray;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1 <= q_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (q_pop) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  // Window columns: entries 0..2 are two columns back, 3..5 one column back,
  // each ordered top, middle, bottom. The right column comes straight from
  // the line buffers and the new gray value.
  always_comb begin
    gx = (12'(signed'({1'b0, rd_two_above})) - 12'(signed'({1'b0, win[0]})))
       + ((12'(signed'({1'b0, rd_above})) - 12'(signed'({1'b0, win[1]}))) <<< 1)
       + (12'(signed'({1'b0, s1.gray})) - 12'(signed'({1'b0, win[2]})));
    gy = (12'(signed'({1'b0, win[2]})) + (12'(signed'({1'b0, win[5]})) <<< 1)
          + 12'(signed'({1'b0, s1.gray})))
       - (12'(signed'({1'b0, win[0]})) + (12'(signed'({1'b0, win[3]})) <<< 1)
          + 12'(signed'({1'b0, rd_two_above})));
    abs_gx  = gx[11] ? 12'(-gx) : 12'(gx);
    abs_gy  = gy[11] ? 12'(-gy) : 12'(gy);
    mag     = abs_gx + abs_gy;
    mag_sat = (mag > 12'(EDGE_MAX)) ? EDGE_MAX : mag[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (s1_move) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= rd_two_above;
      win[4] <= rd_above;
      win[5] <= s1.gray;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      edge_res  <= s1.interior ? mag_sat : 8'd0;
      interior  <= s1.interior;
      frame_end <= s1.last;
    end
  end

endmodule
`default_nettype wire

@@ sv/grayscale_sobel_edge_filter.sv @@
`default_nettype none
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_ready   blue, green, red
// out       output     out_valid / out_ready edge_res, interior, frame_end
// cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One pixel per clock sustained unless the output stalls; a result is held in a queue
// entry, then in s1 with the registered line buffer read, then in the output register.
// Reset restores 640 x 480, frame position zero and a zero window; line
// buffers are not cleared and need no clearing pass.
// A two-entry queue keeps the input open while the output is stalled, until it
// holds two pixels; the configuration port never stalls.
module grayscale_sobel_edge_filter import gsef_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [7:0]           blue,
  input  wire logic [7:0]           green,
  input  wire logic [7:0]           red,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [7:0]                edge_res,
  output logic                      interior,
  output logic                      frame_end,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0]     cfg_data
);

`include "grayscale_sobel_edge_filter_assert.svh"

  q_stat_t  q_stat;
  q_entry_t q_wdata;
  q_entry_t q_rdata;
  logic     q_push;
  logic     q_pop;

  gsef_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .blue      (blue),
    .green     (green),
    .red       (red),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  gsef_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  gsef_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_rdata   (q_rdata),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .edge_res  (edge_res),
    .interior  (interior),
    .frame_end (frame_end)
  );

  `GSEF_ASSERT_SAME(a_border_zero, out_valid && !interior, edge_res == 8'd0, "border result not zero")
  `GSEF_ASSERT_SAME(a_end_interior, out_valid && frame_end, interior, "frame end on border center")
  `GSEF_ASSERT_NEXT(a_push_lands, in_valid && in_ready, !q_stat.empty, "accepted pixel lost in queue")

endmodule
`default_nettype wire

@@ tb/grayscale_sobel_edge_filter_tb.sv @@
module grayscale_sobel_edge_filter_tb import gsef_pkg::*;;

  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_REPORTS    = 10;
  localparam int NUM_PHASES     = 12;

  // Indexes past the register list; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  typedef enum logic {KIND_PIXEL, KIND_WRITE} row_kind_t;
  typedef enum logic {EXP_MODEL, EXP_FIXED} row_check_t;

  typedef struct packed {
    logic [7:0] magnitude;
    logic       is_interior;
    logic       is_last;
  } edge_result_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] index;
    logic [DIM_W-1:0]     data;
    logic [7:0]           blue;
    logic [7:0]           green;
    logic [7:0]           red;
    row_check_t           check;
    edge_result_t         res;
  } step_t;

  localparam int NUM_STEPS = 34;
  localparam step_t DIRECTED [NUM_STEPS] = '{
    // Right after reset the frame is 640 x 480, so the first centers are border.
    '{KIND_PIXEL, REG_FRAME_WIDTH, 12'd0, 8'd255, 8'd255, 8'd255, EXP_FIXED, '{8'd0, 1'b0, 1'b0}},
    '{KIND_PIXEL, REG_FRAME_WIDTH, 12'd0, 8'd0, 8'd0, 8'd0, EXP_FIXED, '{8'd0, 1'b0, 1'b0}},
    '{KIND_WRITE, REG_FRAME_WIDTH, 12'd3, 8'd0, 8'd0, 8'd0, EXP_MODEL, '{8'd0, 1'b0, 1'b0}},
    '{KIND_WRITE, REG_FRAME_HEIGHT, 12'd3, 8'd0, 8'd0, 8'd0, EXP_MODEL, '{8'd0, 1'b0, 1'b0}},
    // White over mid gray over black: vertical gradient saturates.
    '{KIND_PIXEL, REG_FRAME_WIDTH, 12'd0, 8'd255, 8'd255, 8'd255, EXP_FIXED, '{8'd0, 1'b0, 1'b0}},
    '{KIND_PIXEL, REG_FRAME_WIDTH, 12'd0, 8'd255, 8'd255, 8'd255, EXP_FIXED, '{8'd0, 1'b0, 1'b0}},
    '{KIND_PIXEL, REG_FRAME_WIDTH, 12'd0, 8'd255, 8'd255, 8'd255, EXP_FIXED, '{8'd0, 1'b0, 1'b0}},
    '{KIND_PIXEL, REG_FRAME_WIDTH, 12'd0, 8'd128, 8'd128, 8'd128, EXP_FIXED, '{8'd0, 1'b0, 1'b0}},
    '{KIND_PIXEL, REG_FRAME_WIDTH, 12'd0, 8'd128, 8'd128, 8'd128, EXP_FIXED, '{8'd0, 1'b0, 1'b0}},
    '{KIND_PIXEL, REG_FRAME_WIDTH, 12'd0, 8'd128, 8'd128, 8'd128, EXP_FIXED, '{8'd0, 1'b0, 1'b0}},
    '{KIND_PIXEL, REG_FRAME_WIDTH, 12'd0, 8'd0, 8'd0, 8'd0, EXP_FIXED, '{8'd0, 1'b0, 1'b0}},
    '{KIND_PIXEL, REG_FRAME_WIDTH, 12'd0, 8'd0, 8'd0, 8'd0, EXP_FIXED, '{8'd0, 1'b0, 1'b0}},
    '{KIND_PIXEL, REG_FRAME_WIDTH, 12'd0, 8'd0, 8'd0, 8'd0, EXP_FIXED, '{8'd255, 1'b1, 1'b1}},
    // A flat frame has no gradient at its single interior center.
    '{KIND_PIXEL, REG_FRAME_WIDTH, 12'd0, 8'd100, 8'd100, 8'd100, EXP_FIXED, '{8'd0, 1'b0, 1'b0}},
    '{KIND_PIXEL, REG_FRAME_WIDTH, 12'd0, 8'd100, 8'd100, 8'd100, EXP_FIXED, '{8'd0, 1'b0, 1'b0}},
    '{KIND_PIXEL, REG_FRAME_WIDTH, 12'd0, 8'd100, 8'd100, 8'd100, EXP_FIXED, '{8'd0, 1'b0, 1'b0}},
    '{KIND_PIXEL, REG_FRAME_WIDTH, 12'd0, 8'd100, 8'd100, 8'd100, EXP_FIXED, '{8'd0, 1'b0, 1'b0}},
    '{KIND_PIXEL, REG_FRAME_WIDTH, 12'd0, 8'd100, 8'd100, 8'd100, EXP_FIXED, '{8'd0, 1'b0, 1'b0}},
    '{KIND_PIXEL, REG_FRAME_WIDTH, 12'd0, 8'd100, 8'd100, 8'd100, EXP_FIXED, '{8'd0, 1'b0, 1'b0}},
    '{KIND_PIXEL, REG_FRAME_WIDTH, 12'd0, 8'd100, 8'd100, 8'd100, EXP_FIXED, '{8'd0, 1'b0, 1'b0}},
    '{KIND_PIXEL, REG_FRAME_WIDTH, 12'd0, 8'd100, 8'd100, 8'd100, EXP_FIXED, '{8'd0, 1'b0, 1'b0}},
    '{KIND_PIXEL, REG_FRAME_WIDTH, 12'd0, 8'd100, 8'd100, 8'd100, EXP_FIXED, '{8'd0, 1'b1, 1'b1}},
    // Single and mixed channels, with spare-index writes within and between frames.
    '{KIND_PIXEL, REG_FRAME_WIDTH, 12'd0, 8'd0, 8'd0, 8'd255, EXP_MODEL, '{8'd0, 1'b0, 1'b0}},
    '{KIND_PIXEL, REG_FRAME_WIDTH, 12'd0, 8'd0, 8'd255, 8'd0, EXP_MODEL, '{8'd0, 1'b0, 1'b0}},
    '{KIND_PIXEL, REG_FRAME_WIDTH, 12'd0, 8'd255, 8'd0, 8'd0, EXP_MODEL, '{8'd0, 1'b0, 1'b0}},
    '{KIND_PIXEL, REG_FRAME_WIDTH, 12'd0, 8'd255, 8'd0, 8'd255, EXP_MODEL, '{8'd0, 1'b0, 1'b0}},
    '{KIND_WRITE, REG_SPARE_A, 12'hABC, 8'd0, 8'd0, 8'd0, EXP_MODEL, '{8'd0, 1'b0, 1'b0}},
    '{KIND_PIXEL, REG_FRAME_WIDTH, 12'd0, 8'd0, 8'd255, 8'd255, EXP_MODEL, '{8'd0, 1'b0, 1'b0}},
    '{KIND_PIXEL, REG_FRAME_WIDTH, 12'd0, 8'd255, 8'd255, 8'd0, EXP_MODEL, '{8'd0, 1'b0, 1'b0}},
    '{KIND_PIXEL, REG_FRAME_WIDTH, 12'd0, 8'd1, 8'd2, 8'd3, EXP_MODEL, '{8'd0, 1'b0, 1'b0}},
    '{KIND_PIXEL, REG_FRAME_WIDTH, 12'd0, 8'd0, 8'd0, 8'd255, EXP_MODEL, '{8'd0, 1'b0, 1'b0}},
    '{KIND_PIXEL, REG_FRAME_WIDTH, 12'd0, 8'd255, 8'd255, 8'd255, EXP_MODEL, '{8'd0, 1'b0, 1'b0}},
    '{KIND_WRITE, REG_SPARE_B, 12'hFFF, 8'd0, 8'd0, 8'd0, EXP_MODEL, '{8'd0, 1'b0, 1'b0}},
    '{KIND_PIXEL, REG_FRAME_WIDTH, 12'd0, 8'd7, 8'd0, 8'd200, EXP_MODEL, '{8'd0, 1'b0, 1'b0}}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           blue = 8'd0;
  logic [7:0]           green = 8'd0;
  logic [7:0]           red = 8'd0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [7:0]           edge_res;
  logic                 interior;
  logic                 frame_end;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data = '0;

  grayscale_sobel_edge_filter u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .blue      (blue),
    .green     (green),
    .red       (red),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .edge_res  (edge_res),
    .interior  (interior),
    .frame_end (frame_end),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Shadow copy of the filter state.
  logic [7:0]       line_above [MAX_WIDTH];
  logic [7:0]       line_two_above [MAX_WIDTH];
  logic [7:0]       window [6];
  int unsigned      col_pos;
  int unsigned      row_pos;
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;

  edge_result_t expected_edges [$];
  int           fail_count = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           quiet_cycles = 0;

  function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned hi);
    if (v < MIN_DIM) begin
      return int'(MIN_DIM);
    end else if (v > hi) begin
      return hi;
    end
    return 32'(v);
  endfunction

  task automatic sobel_predict(input logic [7:0] b, input logic [7:0] g,
                               input logic [7:0] r, output edge_result_t res);
    int unsigned      w;
    int unsigned      h;
    logic [COL_W-1:0] idx;
    int unsigned      luma_sum;
    logic [7:0]       gray;
    int               p_l, c_l, n_l, p_c, n_c, p_r, c_r, n_r;
    int               gx, gy, mag;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    idx = COL_W'(col_pos % MAX_WIDTH);
    luma_sum = int'(WEIGHT_RED) * int'(r) + int'(WEIGHT_GREEN) * int'(g)
             + int'(WEIGHT_BLUE) * int'(b);
    gray = 8'(luma_sum >> GRAY_SHIFT);
    p_l = int'(window[0]);
    c_l = int'(window[1]);
    n_l = int'(window[2]);
    p_c = int'(window[3]);
    n_c = int'(window[5]);
    p_r = int'(line_two_above[idx]);
    c_r = int'(line_above[idx]);
    n_r = int'(gray);
    gx = (p_r - p_l) + 2 * (c_r - c_l) + (n_r - n_l);
    gy = (n_l + 2 * n_c + n_r) - (p_l + 2 * p_c + p_r);
    mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
    if (mag > int'(EDGE_MAX)) begin
      mag = int'(EDGE_MAX);
    end
    res.is_interior = row_pos >= 2 && col_pos >= 2 && row_pos <= h - 1 && col_pos <= w - 1;
    res.is_last = row_pos >= h - 1 && col_pos >= w - 1;
    res.magnitude = res.is_interior ? 8'(mag) : 8'd0;

    window[0] = window[3];
    window[1] = window[4];
    window[2] = window[5];
    window[3] = 8'(p_r);
    window[4] = 8'(c_r);
    window[5] = gray;
    line_two_above[idx] = 8'(c_r);
    line_above[idx] = gray;

    if (col_pos >= w - 1) begin
      col_pos = 0;
      row_pos = (row_pos >= h - 1) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
                            input bit use_fixed, input edge_result_t fixed_res);
    edge_result_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    sobel_predict(b, g, r, res);
    expected_edges.push_back(use_fixed ? fixed_res : res);
    in_valid <= 1'b1;
    blue     <= b;
    green    <= g;
    red      <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Writes happen only with the pipeline drained.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
    in_valid <= 1'b0;
    while (expected_edges.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_FRAME_WIDTH || idx == REG_FRAME_HEIGHT) begin
      if (idx == REG_FRAME_WIDTH) begin
        width_reg = value;
      end else begin
        height_reg = value;
      end
      col_pos = 0;
      row_pos = 0;
    end
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
      default: begin send_idle_pct = 31; recv_stall_pct = 31; end
    endcase
  endtask

  function automatic logic [DIM_W-1:0] random_dim();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return DIM_W'($urandom_range(1, 2));
      2: return MIN_DIM;
      3: return '1;
      4: return DIM_W'(MAX_WIDTH);
      default: return DIM_W'($urandom_range(3, 12));
    endcase
  endfunction

  task automatic random_pixel(output logic [7:0] b, output logic [7:0] g, output logic [7:0] r);
    logic [7:0] level;
    case ($urandom_range(0, 3))
      0: begin
        b = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        g = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        r = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      end
      3: begin
        level = 8'($urandom_range(0, 255));
        b = level;
        g = level;
        r = level;
      end
      default: begin
        b = 8'($urandom_range(0, 255));
        g = 8'($urandom_range(0, 255));
        r = 8'($urandom_range(0, 255));
      end
    endcase
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : check_results
    edge_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_edges.size() == 0) begin
        if (fail_count < MAX_REPORTS) begin
          $display("unexpected result transaction: edge_res=%0d interior=%0b frame_end=%0b",
                   edge_res, interior, frame_end);
        end
        fail_count++;
      end else begin
        want = expected_edges.pop_front();
        if (edge_res !== want.magnitude || interior !== want.is_interior ||
            frame_end !== want.is_last) begin
          if (fail_count < MAX_REPORTS) begin
            $display("mismatch: expected edge_res=%0d interior=%0b frame_end=%0b, got %0d %0b %0b",
                     want.magnitude, want.is_interior, want.is_last,
                     edge_res, interior, frame_end);
          end
          fail_count++;
        end
      end
    end
  end

  // Ends the run if no pixel or register write transaction completes for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    step_t      row;
    logic [7:0] b, g, r;
    int         n;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      line_above[i] = '0;
      line_two_above[i] = '0;
    end
    for (int i = 0; i < 6; i++) begin
      window[i] = '0;
    end
    col_pos = 0;
    row_pos = 0;
    width_reg = WIDTH_RESET;
    height_reg = HEIGHT_RESET;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    set_idling(0);
    for (int i = 0; i < NUM_STEPS; i++) begin
      row = DIRECTED[i];
      if (row.kind == KIND_WRITE) begin
        write_register(row.index, row.data);
      end else begin
        send_pixel(row.blue, row.green, row.red, row.check == EXP_FIXED, row.res);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_idling(p % 4);
      write_register(REG_FRAME_WIDTH, random_dim());
      write_register(REG_FRAME_HEIGHT, random_dim());
      if ($urandom_range(0, 3) == 0) begin
        write_register($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, DIM_W'($urandom));
      end
      n = $urandom_range(90, 130);
      repeat (n) begin
        random_pixel(b, g, r);
        send_pixel(b, g, r, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (expected_edges.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/gsef_pkg.sv
sv/gsef_front.sv
sv/gsef_queue.sv
sv/gsef_back.sv
sv/grayscale_sobel_edge_filter.sv
tb/grayscale_sobel_edge_filter_tb.sv
